[design/nce_pkg.sv]
package nce_pkg;

    localparam int CACHE_ENTRIES = 8;
    localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int MAX_RESULTS   = 9;
    localparam int CNT_W         = 4;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    // entry states
    localparam logic [2:0] ST_NONE       = 3'd0;
    localparam logic [2:0] ST_INCOMPLETE = 3'd1;
    localparam logic [2:0] ST_REACHABLE  = 3'd2;
    localparam logic [2:0] ST_STALE      = 3'd3;
    localparam logic [2:0] ST_DELAY      = 3'd4;
    localparam logic [2:0] ST_PROBE      = 3'd5;
    localparam logic [2:0] ST_PERMANENT  = 3'd6;

    // actions
    localparam logic [2:0] ACT_LOOKUP = 3'd0;
    localparam logic [2:0] ACT_ALLOC  = 3'd1;
    localparam logic [2:0] ACT_SET    = 3'd2;
    localparam logic [2:0] ACT_TICK   = 3'd3;
    localparam logic [2:0] ACT_FLUSH  = 3'd4;

    // result events
    localparam logic [3:0] EV_LOOKUP     = 4'd0;
    localparam logic [3:0] EV_ALLOCATED  = 4'd1;
    localparam logic [3:0] EV_ALLOC_FAIL = 4'd2;
    localparam logic [3:0] EV_MCAST_SOL  = 4'd3;
    localparam logic [3:0] EV_UCAST_SOL  = 4'd4;
    localparam logic [3:0] EV_RES_FAIL   = 4'd5;
    localparam logic [3:0] EV_UNREACH    = 4'd6;
    localparam logic [3:0] EV_EVICTED    = 4'd7;
    localparam logic [3:0] EV_FLUSHED    = 4'd8;
    localparam logic [3:0] EV_DONE       = 4'd9;

    // configuration register indexes
    localparam logic [1:0] CFG_RETRANS = 2'd0;
    localparam logic [1:0] CFG_MCAST   = 2'd1;
    localparam logic [1:0] CFG_UCAST   = 2'd2;

    localparam logic [31:0] RETRANS_RST = 32'd1000;
    localparam logic [3:0]  SOLICIT_RST = 4'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_time;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [47:0] link_addr;
        logic [2:0]  entry_index;
        logic [2:0]  new_state;
        logic [31:0] timeout;
    } t_item;

    typedef struct packed {
        logic [3:0]  event_res;
        logic        hit;
        logic [2:0]  result_index;
        logic [2:0]  result_state;
        logic [63:0] result_addr_hi;
        logic [63:0] result_addr_lo;
        logic [47:0] result_link_addr;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]  addr;
        logic [31:0] wdata;
    } t_cfg_wr;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_SCAN  = 3'd1,
        OP_SET   = 3'd2,
        OP_EVICT = 3'd3,
        OP_ALLOC = 3'd4,
        OP_FINAL = 3'd5
    } t_op;

    typedef struct packed {
        logic             load;
        t_op              op;
        logic [IDX_W-1:0] idx;
        logic [3:0]       fin_ev;
    } t_cmd;

    typedef struct packed {
        logic       room;
        logic [2:0] action;
        logic       match;
        logic       have_victim;
    } t_status;

endpackage

[design/nce_if.sv]
interface nce_in_if;
    logic          valid;
    logic          ready;
    nce_pkg::t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nce_out_if;
    logic            valid;
    logic            ready;
    nce_pkg::t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface nce_cfg_if;
    logic            valid;
    logic            ready;
    nce_pkg::t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[design/nce_ctrl.sv]
module nce_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  nce_pkg::t_status i_status,
    output nce_pkg::t_cmd    o_cmd
);
    import nce_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RUN   = 5'b00010,
        S_EVICT = 5'b00100,
        S_ALLOC = 5'b01000,
        S_FINAL = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [3:0]       r_fin, n_fin;
    logic             scan_act;

    assign scan_act = (i_status.action == ACT_LOOKUP) || (i_status.action == ACT_ALLOC) ||
                      (i_status.action == ACT_TICK)   || (i_status.action == ACT_FLUSH);

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_fin        = r_fin;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.idx    = r_idx;
        o_cmd.fin_ev = r_fin;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                if (scan_act) begin
                    if (i_status.room) begin
                        o_cmd.op = OP_SCAN;
                        if (i_status.action == ACT_LOOKUP && i_status.match) begin
                            n_state = S_IDLE;
                        end else if (i_status.action == ACT_ALLOC && i_status.match) begin
                            n_state = S_ALLOC;
                        end else if (r_idx == LAST_IDX) begin
                            if (i_status.action == ACT_ALLOC && i_status.have_victim) begin
                                n_state = S_EVICT;
                            end else begin
                                n_state = S_FINAL;
                            end
                            if (i_status.action == ACT_LOOKUP) begin
                                n_fin = EV_LOOKUP;
                            end else if (i_status.action == ACT_ALLOC) begin
                                n_fin = EV_ALLOC_FAIL;
                            end else begin
                                n_fin = EV_DONE;
                            end
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                end else if (i_status.action == ACT_SET) begin
                    if (i_status.room) begin
                        o_cmd.op = OP_SET;
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_fin   = EV_DONE;
                    n_state = S_FINAL;
                end
            end
            S_EVICT: begin
                if (i_status.room) begin
                    o_cmd.op = OP_EVICT;
                    n_state  = S_ALLOC;
                end
            end
            S_ALLOC: begin
                if (i_status.room) begin
                    o_cmd.op = OP_ALLOC;
                    n_state  = S_IDLE;
                end
            end
            S_FINAL: begin
                if (i_status.room) begin
                    o_cmd.op = OP_FINAL;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_fin   <= EV_DONE;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_fin   <= n_fin;
        end
    end

endmodule

[design/nce_dp.sv]
module nce_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nce_pkg::t_cmd     i_cmd,
    output nce_pkg::t_status  o_status,
    input  nce_pkg::t_item    i_item,
    input  logic              i_cfg_valid,
    input  nce_pkg::t_cfg_wr  i_cfg,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output nce_pkg::t_result  o_out
);
    import nce_pkg::*;

    t_item       r_item;
    logic [31:0] r_retrans;
    logic [3:0]  r_mcast, r_ucast;

    logic [2:0]  r_st    [CACHE_ENTRIES];
    logic [63:0] r_ahi   [CACHE_ENTRIES];
    logic [63:0] r_alo   [CACHE_ENTRIES];
    logic [47:0] r_lnk   [CACHE_ENTRIES];
    logic [31:0] r_stamp [CACHE_ENTRIES];
    logic [31:0] r_tmo   [CACHE_ENTRIES];
    logic [3:0]  r_rtr   [CACHE_ENTRIES];

    logic [IDX_W-1:0] r_slot, n_slot;
    logic             r_vvalid, n_vvalid;
    logic             r_vstale, n_vstale;
    logic [31:0]      r_vage, n_vage;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid;
    t_result          r_out;

    logic [IDX_W-1:0] rd;
    logic [2:0]  cur_st, nst, wst;
    logic [63:0] cur_ahi, cur_alo, wahi, walo;
    logic [47:0] cur_lnk, wlnk;
    logic [31:0] cur_stamp, cur_tmo, wstamp, wtmo, now, diff, age;
    logic [3:0]  cur_rtr, wrtr, rtr_b;
    logic        w_en, emit, expd, can_rep, set_ok, room, match, have_victim, cand, cs;
    logic [2:0]  ridx;
    t_result     res;

    assign room    = !r_out_valid || i_out_ready;
    assign now     = r_item.now_time;
    assign nst     = (r_item.new_state > ST_PERMANENT) ? ST_NONE : r_item.new_state;
    assign set_ok  = 32'(r_item.entry_index) < CACHE_ENTRIES;
    assign can_rep = r_cnt < CNT_W'(MAX_RESULTS - 1);

    always_comb begin
        if (i_cmd.op == OP_EVICT || i_cmd.op == OP_ALLOC) begin
            rd = r_slot;
        end else if (i_cmd.op == OP_SET) begin
            rd = IDX_W'(r_item.entry_index);
        end else begin
            rd = i_cmd.idx;
        end
    end

    assign ridx      = 3'(rd);
    assign cur_st    = r_st[rd];
    assign cur_ahi   = r_ahi[rd];
    assign cur_alo   = r_alo[rd];
    assign cur_lnk   = r_lnk[rd];
    assign cur_stamp = r_stamp[rd];
    assign cur_tmo   = r_tmo[rd];
    assign cur_rtr   = r_rtr[rd];
    assign diff      = now - (cur_stamp + cur_tmo);
    assign expd      = !diff[31];
    assign age       = now - cur_stamp;
    assign rtr_b     = (cur_rtr == 4'hF) ? 4'hF : cur_rtr + 4'd1;
    assign cs        = (cur_st == ST_STALE);
    assign cand      = (r_item.action == ACT_ALLOC) && (cur_st != ST_NONE) &&
                       (cur_st != ST_PERMANENT);

    always_comb begin
        w_en     = 1'b0;
        wst      = cur_st;
        wahi     = cur_ahi;
        walo     = cur_alo;
        wlnk     = cur_lnk;
        wstamp   = cur_stamp;
        wtmo     = cur_tmo;
        wrtr     = cur_rtr;
        emit     = 1'b0;
        res      = '0;
        n_slot   = r_slot;
        n_vvalid = r_vvalid;
        n_vstale = r_vstale;
        n_vage   = r_vage;
        n_cnt    = r_cnt;
        match    = 1'b0;
        have_victim = r_vvalid;
        if (r_item.action == ACT_LOOKUP) begin
            match = (cur_st != ST_NONE) && (cur_ahi == r_item.addr_hi) &&
                    (cur_alo == r_item.addr_lo);
        end else if (r_item.action == ACT_ALLOC) begin
            match = (cur_st == ST_NONE);
            have_victim = r_vvalid || cand;
        end
        if (i_cmd.load) begin
            n_cnt    = '0;
            n_vvalid = 1'b0;
        end
        unique case (i_cmd.op)
            OP_NONE: begin
            end
            OP_SCAN: begin
                if (r_item.action == ACT_LOOKUP) begin
                    if (match) begin
                        emit = 1'b1;
                        res  = '{EV_LOOKUP, 1'b1, ridx, cur_st, cur_ahi, cur_alo, cur_lnk, 1'b1};
                    end
                end else if (r_item.action == ACT_ALLOC) begin
                    if (match) begin
                        n_slot = rd;
                    end else if (cand) begin
                        // stale beats non-stale, then strictly oldest
                        if (!r_vvalid || (cs && !r_vstale) ||
                            (cs == r_vstale && age > r_vage)) begin
                            n_slot   = rd;
                            n_vvalid = 1'b1;
                            n_vstale = cs;
                            n_vage   = age;
                        end
                    end
                end else if (r_item.action == ACT_TICK) begin
                    unique case (cur_st)
                        ST_PERMANENT, ST_STALE: begin
                        end
                        ST_INCOMPLETE, ST_PROBE: begin
                            if (expd) begin
                                w_en   = 1'b1;
                                wrtr   = rtr_b;
                                wstamp = now;
                                emit   = can_rep;
                                if (rtr_b < ((cur_st == ST_INCOMPLETE) ? r_mcast : r_ucast)) begin
                                    wtmo = r_retrans;
                                    res.event_res = (cur_st == ST_INCOMPLETE) ?
                                                    EV_MCAST_SOL : EV_UCAST_SOL;
                                end else begin
                                    wst = ST_NONE;
                                    res.event_res = (cur_st == ST_INCOMPLETE) ?
                                                    EV_RES_FAIL : EV_UNREACH;
                                end
                            end
                        end
                        ST_REACHABLE: begin
                            if (expd) begin
                                w_en   = 1'b1;
                                wst    = ST_STALE;
                                wstamp = now;
                            end
                        end
                        ST_DELAY: begin
                            if (expd) begin
                                w_en   = 1'b1;
                                wrtr   = 4'd0;
                                wtmo   = r_retrans;
                                wst    = ST_PROBE;
                                wstamp = now;
                                emit   = can_rep;
                                res.event_res = EV_UCAST_SOL;
                            end
                        end
                        default: begin
                            w_en   = 1'b1;
                            wst    = ST_NONE;
                            wstamp = now;
                        end
                    endcase
                    res.result_index     = ridx;
                    res.result_state     = wst;
                    res.result_addr_hi   = cur_ahi;
                    res.result_addr_lo   = cur_alo;
                    res.result_link_addr = cur_lnk;
                end else if (r_item.action == ACT_FLUSH) begin
                    if (cur_st != ST_PERMANENT) begin
                        w_en   = 1'b1;
                        wst    = ST_NONE;
                        wstamp = now;
                        emit   = can_rep && (cur_st != ST_NONE);
                        res    = '{EV_FLUSHED, 1'b0, ridx, ST_NONE, cur_ahi, cur_alo,
                                   cur_lnk, 1'b0};
                    end
                end
                if (emit) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            OP_SET: begin
                emit = 1'b1;
                if (set_ok) begin
                    w_en   = 1'b1;
                    wst    = nst;
                    wlnk   = r_item.link_addr;
                    wtmo   = r_item.timeout;
                    wstamp = now;
                    res    = '{EV_DONE, 1'b0, r_item.entry_index, nst, cur_ahi, cur_alo,
                               r_item.link_addr, 1'b1};
                end else begin
                    res.event_res    = EV_DONE;
                    res.result_index = r_item.entry_index;
                    res.last         = 1'b1;
                end
            end
            OP_EVICT: begin
                emit = 1'b1;
                res  = '{EV_EVICTED, 1'b0, ridx, ST_NONE, cur_ahi, cur_alo, cur_lnk, 1'b0};
            end
            OP_ALLOC: begin
                w_en   = 1'b1;
                wst    = nst;
                wahi   = r_item.addr_hi;
                walo   = r_item.addr_lo;
                wlnk   = r_item.link_addr;
                wstamp = now;
                wtmo   = r_item.timeout;
                wrtr   = 4'd0;
                emit   = 1'b1;
                res    = '{EV_ALLOCATED, 1'b0, ridx, nst, r_item.addr_hi, r_item.addr_lo,
                           r_item.link_addr, 1'b1};
            end
            OP_FINAL: begin
                emit          = 1'b1;
                res.event_res = i_cmd.fin_ev;
                res.last      = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_status.room        = room;
    assign o_status.action      = r_item.action;
    assign o_status.match       = match;
    assign o_status.have_victim = have_victim;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CACHE_ENTRIES; k++) begin
                r_st[k]    <= ST_NONE;
                r_ahi[k]   <= '0;
                r_alo[k]   <= '0;
                r_lnk[k]   <= '0;
                r_stamp[k] <= '0;
                r_tmo[k]   <= '0;
                r_rtr[k]   <= '0;
            end
        end else if (w_en) begin
            r_st[rd]    <= wst;
            r_ahi[rd]   <= wahi;
            r_alo[rd]   <= walo;
            r_lnk[rd]   <= wlnk;
            r_stamp[rd] <= wstamp;
            r_tmo[rd]   <= wtmo;
            r_rtr[rd]   <= wrtr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retrans   <= RETRANS_RST;
            r_mcast     <= SOLICIT_RST;
            r_ucast     <= SOLICIT_RST;
            r_slot      <= '0;
            r_vvalid    <= 1'b0;
            r_vstale    <= 1'b0;
            r_vage      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg.addr)
                    CFG_RETRANS: r_retrans <= i_cfg.wdata;
                    CFG_MCAST:   r_mcast   <= i_cfg.wdata[3:0];
                    CFG_UCAST:   r_ucast   <= i_cfg.wdata[3:0];
                    default: begin
                    end
                endcase
            end
            r_slot   <= n_slot;
            r_vvalid <= n_vvalid;
            r_vstale <= n_vstale;
            r_vage   <= n_vage;
            r_cnt    <= n_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> room) else $error("result written over an untaken result");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS - 1)) else $error("result budget overrun");
    a_alloc_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ALLOC) |=> (r_st[$past(r_slot)] == $past(nst)))
        else $error("allocated entry has wrong state");
`endif

endmodule

[design/neighbor_cache_engine.sv]
// ipv6 neighbor cache of CACHE_ENTRIES entries (nce_pkg). one item in, one to nine result
// items out, the final one flagged by last. lookup, allocate, tick and flush walk the
// entry file one entry per cycle through its single read/write port, scanning up to
// CACHE_ENTRIES entries before the eviction, allocation or closing result (lookup stops
// at the first hit, allocate at the first free entry); set writes its entry, if the index
// is valid, and its result with no scan, and an undefined action goes to the closing result. the scan
// also pauses whenever the output register holds a result not yet taken. a new item is
// taken only once the previous one has produced its last result into the output register.
// configuration writes are always accepted and must only be issued while the block is
// idle. the entry file is cleared directly by reset, no clearing pass is needed.
module neighbor_cache_engine (
    input logic        i_clk,
    input logic        i_rst_n,
    nce_in_if.sink     i_in,
    nce_out_if.source  o_out,
    nce_cfg_if.sink    i_cfg
);
    import nce_pkg::*;

    t_cmd    cmd;
    t_status status;

    // config port never stalls
    assign i_cfg.ready = 1'b1;

    // sequencer: walks the entry pointer and picks the operation each cycle
    nce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // entry file, per-entry update logic, victim tracking and output register
    nce_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_in.data),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg       (i_cfg.data),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out       (o_out.data)
    );

endmodule
